@@ sv/assert_macros.svh @@
// assertion macros included by the data transfer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked while out of reset, sampled on clk
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/c8dtu_pkg.sv @@
// shared types and constants of the data transfer unit
`default_nettype none
package c8dtu_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int NUM_REGS      = 7;
  localparam int MEM_W         = 9;   // written mark on top of a data byte

  typedef logic [7:0] byte_t;
  typedef logic [NUM_REGS-1:0][7:0] regs_t;

  // command codes
  localparam logic [3:0] CMD_MOV  = 4'd0;
  localparam logic [3:0] CMD_MVI  = 4'd1;
  localparam logic [3:0] CMD_LDA  = 4'd2;
  localparam logic [3:0] CMD_STA  = 4'd3;
  localparam logic [3:0] CMD_LDAX = 4'd4;
  localparam logic [3:0] CMD_STAX = 4'd5;
  localparam logic [3:0] CMD_LHLD = 4'd6;
  localparam logic [3:0] CMD_SHLD = 4'd7;
  localparam logic [3:0] CMD_XCHG = 4'd8;
  localparam logic [3:0] CMD_LXI  = 4'd9;
  localparam logic [3:0] CMD_SET  = 4'd10;

  // register codes
  localparam logic [2:0] REG_A    = 3'd0;
  localparam logic [2:0] REG_B    = 3'd1;
  localparam logic [2:0] REG_C    = 3'd2;
  localparam logic [2:0] REG_D    = 3'd3;
  localparam logic [2:0] REG_E    = 3'd4;
  localparam logic [2:0] REG_H    = 3'd5;
  localparam logic [2:0] REG_L    = 3'd6;
  localparam logic [2:0] REG_NONE = 3'd7;

  // register pair codes
  localparam logic [1:0] PAIR_BC   = 2'd0;
  localparam logic [1:0] PAIR_DE   = 2'd1;
  localparam logic [1:0] PAIR_HL   = 2'd2;
  localparam logic [1:0] PAIR_NONE = 2'd3;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [MEM_W-1:0]     wdata;
  } mem_req_t;

  typedef struct packed {
    logic  status;
    regs_t regs;
  } result_t;

endpackage
`default_nettype wire

@@ sv/c8dtu_mem.sv @@
// single-port byte memory with written marks, registered read data
`default_nettype none
module c8dtu_mem #(
  parameter int ADDR_BITS = c8dtu_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire c8dtu_pkg::mem_req_t         req,
  input  wire logic [ADDR_BITS-1:0]        addr,
  output logic [c8dtu_pkg::MEM_W-1:0]      rdata
);
  import c8dtu_pkg::*;

  logic [MEM_W-1:0] mem [2**ADDR_BITS];
  logic [MEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[addr] <= req.wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/c8dtu_outq.sv @@
// two-entry result queue between the sequencer and the output channel
`default_nettype none
module c8dtu_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire c8dtu_pkg::result_t push_data,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output c8dtu_pkg::result_t      out_data,
  output logic                    full
);
  import c8dtu_pkg::*;

  result_t     data_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid & out_ready;
  assign out_data  = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ sv/cpu8bit_data_transfer_unit.sv @@
// Data transfer unit of an 8-bit CPU: register file A..L in flip-flops and a
// byte memory of 2**ADDR_BITS entries, each with a written mark, held in one
// single-port memory with registered read data. After reset a clearing pass
// writes every entry and so clears every mark; in_ready stays low until it
// ends. Register moves, immediates, XCHG, LXI and all single-byte stores
// (STA, STAX, SET) finish in S_IDLE; LDA and LDAX wait in S_LOAD for the read
// data, SHLD writes L then H via S_SH2, and LHLD reads L then H via S_LH1 and
// S_LH2. Results go through a two-entry queue, so the unit keeps accepting
// items while earlier results wait on out_ready, until the queue is full.
`default_nettype none
module cpu8bit_data_transfer_unit #(
  parameter int ADDR_BITS = c8dtu_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_command,
  input  wire logic [2:0]  in_dest_reg,
  input  wire logic [2:0]  in_src_reg,
  input  wire logic [1:0]  in_reg_pair,
  input  wire logic [15:0] in_imm16,
  input  wire logic [7:0]  in_imm8,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [7:0]       out_reg_a_out,
  output logic [7:0]       out_reg_b_out,
  output logic [7:0]       out_reg_c_out,
  output logic [7:0]       out_reg_d_out,
  output logic [7:0]       out_reg_e_out,
  output logic [7:0]       out_reg_h_out,
  output logic [7:0]       out_reg_l_out
);
  import c8dtu_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_LH1,
    S_LH2,
    S_SH2
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   clr_cnt_r, clr_cnt_nxt;
  regs_t                  regs_r, regs_nxt;
  logic [ADDR_BITS-1:0]   addr_r, addr_nxt;
  byte_t                  lo_r, lo_nxt;
  logic                   miss_r, miss_nxt;
  logic                   rep_r, rep_nxt;

  mem_req_t               mem_req;
  logic [ADDR_BITS-1:0]   mem_addr;
  logic [MEM_W-1:0]       mem_rdata;

  logic                   q_push;
  result_t                q_push_data;
  result_t                q_data;
  logic                   q_full;
  logic                   push_status;

  logic                   accept;
  logic                   dst_ok, src_ok, pair_ok;
  logic [15:0]            pair_word;
  logic [ADDR_BITS-1:0]   imm_addr, pair_addr, addr_inc;
  byte_t                  rd_byte;
  logic                   rd_miss;

  assign in_ready = (state_r == S_IDLE) & ~q_full;
  assign accept   = in_valid & in_ready;

  assign dst_ok  = (in_dest_reg != REG_NONE);
  assign src_ok  = (in_src_reg != REG_NONE);
  assign pair_ok = (in_reg_pair != PAIR_NONE);

  always_comb begin
    unique case (in_reg_pair)
      PAIR_BC: pair_word = {regs_r[REG_B], regs_r[REG_C]};
      PAIR_DE: pair_word = {regs_r[REG_D], regs_r[REG_E]};
      PAIR_HL: pair_word = {regs_r[REG_H], regs_r[REG_L]};
      default: pair_word = 16'h0000;
    endcase
  end

  assign imm_addr  = in_imm16[ADDR_BITS-1:0];
  assign pair_addr = pair_word[ADDR_BITS-1:0];
  assign addr_inc  = addr_r + ADDR_BITS'(1);

  // an unwritten byte reads as zero
  assign rd_miss = ~mem_rdata[MEM_W-1];
  assign rd_byte = rd_miss ? 8'h00 : mem_rdata[7:0];

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    regs_nxt    = regs_r;
    addr_nxt    = addr_r;
    lo_nxt      = lo_r;
    miss_nxt    = miss_r;
    rep_nxt     = rep_r;
    mem_req     = '0;
    mem_addr    = imm_addr;
    q_push      = 1'b0;
    push_status = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_req     = '{en: 1'b1, we: 1'b1, wdata: '0};
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_BITS'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          q_push = 1'b1;
          unique case (in_command)
            CMD_MOV: begin
              if (dst_ok && src_ok) begin
                regs_nxt[in_dest_reg] = regs_r[in_src_reg];
              end
            end
            CMD_MVI: begin
              if (dst_ok) begin
                regs_nxt[in_dest_reg] = in_imm8;
              end
            end
            CMD_LDA: begin
              mem_req   = '{en: 1'b1, we: 1'b0, wdata: '0};
              rep_nxt   = 1'b0;
              q_push    = 1'b0;
              state_nxt = S_LOAD;
            end
            CMD_STA: begin
              mem_req = '{en: 1'b1, we: 1'b1, wdata: {1'b1, regs_r[REG_A]}};
            end
            CMD_LDAX: begin
              if (pair_ok) begin
                mem_req   = '{en: 1'b1, we: 1'b0, wdata: '0};
                mem_addr  = pair_addr;
                rep_nxt   = 1'b1;
                q_push    = 1'b0;
                state_nxt = S_LOAD;
              end
            end
            CMD_STAX: begin
              if (pair_ok) begin
                mem_req  = '{en: 1'b1, we: 1'b1, wdata: {1'b1, regs_r[REG_A]}};
                mem_addr = pair_addr;
              end
            end
            CMD_LHLD: begin
              mem_req   = '{en: 1'b1, we: 1'b0, wdata: '0};
              addr_nxt  = imm_addr;
              q_push    = 1'b0;
              state_nxt = S_LH1;
            end
            CMD_SHLD: begin
              mem_req   = '{en: 1'b1, we: 1'b1, wdata: {1'b1, regs_r[REG_L]}};
              addr_nxt  = imm_addr;
              q_push    = 1'b0;
              state_nxt = S_SH2;
            end
            CMD_XCHG: begin
              regs_nxt[REG_H] = regs_r[REG_D];
              regs_nxt[REG_D] = regs_r[REG_H];
              regs_nxt[REG_L] = regs_r[REG_E];
              regs_nxt[REG_E] = regs_r[REG_L];
            end
            CMD_LXI: begin
              unique case (in_reg_pair)
                PAIR_BC: begin
                  regs_nxt[REG_B] = in_imm16[15:8];
                  regs_nxt[REG_C] = in_imm16[7:0];
                end
                PAIR_DE: begin
                  regs_nxt[REG_D] = in_imm16[15:8];
                  regs_nxt[REG_E] = in_imm16[7:0];
                end
                PAIR_HL: begin
                  regs_nxt[REG_H] = in_imm16[15:8];
                  regs_nxt[REG_L] = in_imm16[7:0];
                end
                default: regs_nxt = regs_r;
              endcase
            end
            CMD_SET: begin
              mem_req = '{en: 1'b1, we: 1'b1, wdata: {1'b1, in_imm8}};
            end
            default: regs_nxt = regs_r;
          endcase
        end
      end
      S_LOAD: begin
        regs_nxt[REG_A] = rd_byte;
        push_status     = rep_r & rd_miss;
        q_push          = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_LH1: begin
        // low byte is back, fetch the high byte
        lo_nxt    = rd_byte;
        miss_nxt  = rd_miss;
        mem_req   = '{en: 1'b1, we: 1'b0, wdata: '0};
        mem_addr  = addr_inc;
        state_nxt = S_LH2;
      end
      S_LH2: begin
        regs_nxt[REG_L] = lo_r;
        regs_nxt[REG_H] = rd_byte;
        push_status     = miss_r | rd_miss;
        q_push          = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SH2: begin
        mem_req   = '{en: 1'b1, we: 1'b1, wdata: {1'b1, regs_r[REG_H]}};
        mem_addr  = addr_inc;
        q_push    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign q_push_data = '{status: push_status, regs: regs_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      regs_r    <= '0;
      rep_r     <= 1'b0;
      miss_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      regs_r    <= regs_nxt;
      rep_r     <= rep_nxt;
      miss_r    <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    lo_r   <= lo_nxt;
  end

  c8dtu_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  c8dtu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (q_data),
    .full      (q_full)
  );

  assign out_status    = q_data.status;
  assign out_reg_a_out = q_data.regs[REG_A];
  assign out_reg_b_out = q_data.regs[REG_B];
  assign out_reg_c_out = q_data.regs[REG_C];
  assign out_reg_d_out = q_data.regs[REG_D];
  assign out_reg_e_out = q_data.regs[REG_E];
  assign out_reg_h_out = q_data.regs[REG_H];
  assign out_reg_l_out = q_data.regs[REG_L];

  `ASSERT_ALWAYS(a_no_accept_in_clear, (state_r == S_CLEAR) |-> !in_ready)
  `ASSERT_CHK(a_no_push_when_full, q_push |-> !q_full)
  `ASSERT_CHK(a_lhld_second_read, (accept && in_command == CMD_LHLD) |=> state_r == S_LH1)
  `ASSERT_CHK(a_status_from_read, (q_push && push_status) |-> (state_r == S_LOAD || state_r == S_LH2))

endmodule
`default_nettype wire
